FILE: hw/rtl/btheap_pkg.sv
// Shared types and constants for the boundary-tag first-fit heap.
// Holds field widths, operation and status codes, FSM states and the
// command and flag structs between the controller and the datapath.
package btheap_pkg;

    localparam int KIND_W   = 2;
    localparam int SIZE_W   = 13;
    localparam int ADDR_W   = 10;
    localparam int STATUS_W = 3;
    localparam int CNT_W    = 10;
    localparam int OVER_W   = 11;

    typedef enum logic [KIND_W-1:0] {
        KIND_INIT,
        KIND_ALLOC,
        KIND_FREE,
        KIND_STATS
    } kind_t;

    localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD    = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOFIT  = 3'd3;
    localparam logic [STATUS_W-1:0] ST_NOINIT = 3'd4;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_LATCH,
        OP_INIT_LO,
        OP_INIT_HI,
        OP_RD_H,
        OP_SCAN,
        OP_SPLIT0,
        OP_SPLIT1,
        OP_SPLIT2,
        OP_SPLIT3,
        OP_RD_END,
        OP_END_CK,
        OP_WR_H_NEG,
        OP_WR_END_NEG,
        OP_HDR_CK,
        OP_RD_HM1,
        OP_PREV_CK,
        OP_RD_AUX,
        OP_PREV_TAKE,
        OP_MG_RD,
        OP_MG_CK,
        OP_MG_W0,
        OP_MG_W1,
        OP_NXT_CK,
        OP_ST_STEP
    } dp_op_t;

    typedef enum logic [5:0] {
        S_IDLE,
        S_DECODE,
        S_INIT_LO,
        S_INIT_HI,
        S_SCAN_RD,
        S_SCAN,
        S_AL_SPLIT0,
        S_AL_SPLIT1,
        S_AL_SPLIT2,
        S_AL_SPLIT3,
        S_AL_RD_END,
        S_AL_END_CK,
        S_AL_WR_H,
        S_AL_WR_END,
        S_FR_RD_H,
        S_FR_H_CK,
        S_FR_RD_END,
        S_FR_END_CK,
        S_FR_WR_H,
        S_FR_WR_END,
        S_FR_RD_HM1,
        S_FR_PREV_CK,
        S_FR_RD_PREV,
        S_FR_PREV_TAG,
        S_MG_RD,
        S_MG_CK,
        S_MG_W0,
        S_MG_W1,
        S_FR_RELOAD,
        S_FR_NXT_CK,
        S_FR_NXT_TAG,
        S_ST_RD,
        S_ST_WALK,
        S_ST_FIN
    } ctl_state_t;

    typedef struct packed {
        dp_op_t               op;
        logic                 finish;
        logic [STATUS_W-1:0]  status;
    } dp_cmd_t;

    typedef struct packed {
        logic  ready;
        kind_t kind;
        logic  words_zero;
        logic  free_oob;
        logic  h_zero;
        logic  rd_neg;
        logic  rd_pos;
        logic  end_oob;
        logic  next_oob;
        logic  fit;
        logic  split;
        logic  mismatch;
        logic  prev_skip;
        logic  ls_oob;
        logic  le_oob;
    } dp_flags_t;

endpackage

FILE: hw/rtl/btheap_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Stands alone; depends on nothing else in the project.
module btheap_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/btheap_dp.sv
// Datapath of the heap: tag RAM, address and room arithmetic, statistics
// totals and the result registers. Uses btheap_pkg and btheap_ram.
module btheap_dp #(
    parameter int HEAP_WORDS = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  btheap_pkg::dp_cmd_t              cmd,
    input  logic [btheap_pkg::KIND_W-1:0]    kind,
    input  logic [btheap_pkg::SIZE_W-1:0]    size_bytes,
    input  logic [btheap_pkg::ADDR_W-1:0]    address,
    output btheap_pkg::dp_flags_t            flags,
    output logic                             done,
    output logic [btheap_pkg::STATUS_W-1:0]  status,
    output logic [btheap_pkg::ADDR_W-1:0]    block_address,
    output logic [btheap_pkg::CNT_W-1:0]     used_words,
    output logic [btheap_pkg::CNT_W-1:0]     free_words,
    output logic [btheap_pkg::CNT_W-1:0]     used_count,
    output logic [btheap_pkg::CNT_W-1:0]     free_count,
    output logic [btheap_pkg::OVER_W-1:0]    overhead_words
);
    import btheap_pkg::*;

    localparam int AW  = $clog2(HEAP_WORDS);
    localparam int TW  = AW + 1;
    localparam int WDW = SIZE_W - 1;
    localparam int W   = (AW + 2 > WDW + 1) ? AW + 2 : WDW + 1;
    localparam logic [W-1:0]  HEAP_N   = W'(HEAP_WORDS);
    localparam logic [TW-1:0] INIT_TAG = TW'(2 - HEAP_WORDS);
    localparam logic [AW-1:0] LAST_IDX = AW'(HEAP_WORDS - 1);

    kind_t            kind_reg, kind_next;
    logic [WDW-1:0]   words_reg, words_next;
    logic [AW-1:0]    h_reg, h_next;
    logic [AW-1:0]    end_reg, end_next;
    logic [AW-1:0]    aux_reg, aux_next;
    logic [TW-1:0]    hdr_reg, hdr_next;
    logic [TW-1:0]    tend_reg, tend_next;
    logic [TW-1:0]    room_reg, room_next;
    logic             free_oob_reg, free_oob_next;
    logic             ready_reg, ready_next;
    logic [AW:0]      uw_reg, uw_next;
    logic [AW:0]      fw_reg, fw_next;
    logic [AW:0]      uc_reg, uc_next;
    logic [AW:0]      fc_reg, fc_next;
    logic             done_reg, done_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [ADDR_W-1:0]   baddr_reg, baddr_next;
    logic [CNT_W-1:0]    uwo_reg, uwo_next;
    logic [CNT_W-1:0]    fwo_reg, fwo_next;
    logic [CNT_W-1:0]    uco_reg, uco_next;
    logic [CNT_W-1:0]    fco_reg, fco_next;
    logic [OVER_W-1:0]   over_reg, over_next;

    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [TW-1:0]   mem_wdata;
    logic [AW-1:0]   mem_raddr;
    logic [TW-1:0]   rdata;

    logic [TW-1:0]   rd_room;
    logic [W-1:0]    h_ext, room_ext, words_ext;
    logic [W-1:0]    sum1, sum2, rest, neg_rest, ls, le, prev, mg_room, neg_mg;
    logic [W-1:0]    h_words, total, addr_ext, fh;
    logic [SIZE_W:0] size_up;

    btheap_ram #(
        .WIDTH (TW),
        .DEPTH (HEAP_WORDS)
    ) u_tag_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        rd_room   = rdata[TW-1] ? (~rdata + 1'b1) : rdata;
        h_ext     = W'(h_reg);
        room_ext  = W'(rd_room);
        words_ext = W'(words_reg);
        sum1      = h_ext + room_ext + W'(1);
        sum2      = sum1 + W'(1);
        rest      = W'(room_reg) - words_ext - W'(2);
        neg_rest  = W'(0) - rest;
        ls        = h_ext + W'(room_reg) + W'(2);
        le        = W'(aux_reg) + room_ext + W'(1);
        prev      = h_ext - room_ext - W'(2);
        mg_room   = W'(end_reg) - h_ext - W'(1);
        neg_mg    = W'(0) - mg_room;
        h_words   = h_ext + words_ext;
        total     = W'(uw_reg) + W'(fw_reg);
        addr_ext  = W'(address);
        fh        = addr_ext - W'(1);
        size_up   = {1'b0, size_bytes} + (SIZE_W + 1)'(3);
    end

    always_comb
    begin
        flags.ready      = ready_reg;
        flags.kind       = kind_reg;
        flags.words_zero = (words_reg == '0);
        flags.free_oob   = free_oob_reg;
        flags.h_zero     = (h_reg == '0);
        flags.rd_neg     = rdata[TW-1];
        flags.rd_pos     = !rdata[TW-1] && (rdata != '0);
        flags.end_oob    = (sum1 >= HEAP_N);
        flags.next_oob   = (sum2 >= HEAP_N);
        flags.fit        = rdata[TW-1] && (words_ext <= room_ext) && (sum1 < HEAP_N);
        flags.split      = (room_ext > words_ext + W'(2));
        flags.mismatch   = (rdata != hdr_reg);
        flags.prev_skip  = (room_ext + W'(2) > h_ext);
        flags.ls_oob     = (ls >= HEAP_N);
        flags.le_oob     = (le >= HEAP_N);
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = h_reg;
        mem_wdata = ~hdr_reg + 1'b1;
        mem_raddr = h_reg;
        case (cmd.op)
            OP_INIT_LO:
            begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = INIT_TAG;
            end
            OP_INIT_HI:
            begin
                mem_we    = 1'b1;
                mem_waddr = LAST_IDX;
                mem_wdata = INIT_TAG;
            end
            OP_SCAN, OP_NXT_CK, OP_ST_STEP:
            begin
                mem_raddr = AW'(sum2);
            end
            OP_SPLIT0:
            begin
                mem_we    = 1'b1;
                mem_wdata = TW'(words_reg);
            end
            OP_SPLIT1:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(h_words + W'(1));
                mem_wdata = TW'(words_reg);
            end
            OP_SPLIT2:
            begin
                mem_we    = 1'b1;
                mem_waddr = AW'(h_words + W'(2));
                mem_wdata = neg_rest[TW-1:0];
            end
            OP_SPLIT3:
            begin
                mem_we    = 1'b1;
                mem_waddr = end_reg;
                mem_wdata = neg_rest[TW-1:0];
            end
            OP_RD_END:
            begin
                mem_raddr = end_reg;
            end
            OP_WR_H_NEG:
            begin
                mem_we    = 1'b1;
            end
            OP_WR_END_NEG:
            begin
                mem_we    = 1'b1;
                mem_waddr = end_reg;
                mem_wdata = ~tend_reg + 1'b1;
            end
            OP_RD_HM1:
            begin
                mem_raddr = h_reg - AW'(1);
            end
            OP_RD_AUX:
            begin
                mem_raddr = aux_reg;
            end
            OP_MG_RD:
            begin
                mem_raddr = AW'(ls);
            end
            OP_MG_W0:
            begin
                mem_we    = 1'b1;
                mem_wdata = neg_mg[TW-1:0];
            end
            OP_MG_W1:
            begin
                mem_we    = 1'b1;
                mem_waddr = end_reg;
                mem_wdata = neg_mg[TW-1:0];
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        kind_next     = kind_reg;
        words_next    = words_reg;
        h_next        = h_reg;
        end_next      = end_reg;
        aux_next      = aux_reg;
        hdr_next      = hdr_reg;
        tend_next     = tend_reg;
        room_next     = room_reg;
        free_oob_next = free_oob_reg;
        ready_next    = ready_reg;
        uw_next       = uw_reg;
        fw_next       = fw_reg;
        uc_next       = uc_reg;
        fc_next       = fc_reg;
        case (cmd.op)
            OP_LATCH:
            begin
                kind_next     = kind_t'(kind);
                words_next    = size_up[SIZE_W:2];
                free_oob_next = (address == '0) || (fh >= HEAP_N);
                h_next        = (kind_t'(kind) == KIND_FREE) ? AW'(fh) : '0;
                uw_next       = '0;
                fw_next       = '0;
                uc_next       = '0;
                fc_next       = '0;
            end
            OP_INIT_HI:
            begin
                ready_next = 1'b1;
            end
            OP_SCAN:
            begin
                if (flags.fit)
                begin
                    hdr_next  = rdata;
                    end_next  = AW'(sum1);
                    room_next = rd_room;
                end
                else
                begin
                    h_next = AW'(sum2);
                end
            end
            OP_END_CK:
            begin
                tend_next = rdata;
            end
            OP_HDR_CK:
            begin
                hdr_next = rdata;
                end_next = AW'(sum1);
            end
            OP_PREV_CK:
            begin
                aux_next = AW'(prev);
            end
            OP_PREV_TAKE:
            begin
                h_next    = aux_reg;
                room_next = rd_room;
            end
            OP_MG_RD:
            begin
                aux_next = AW'(ls);
            end
            OP_MG_CK:
            begin
                end_next = AW'(le);
            end
            OP_NXT_CK:
            begin
                room_next = rd_room;
            end
            OP_ST_STEP:
            begin
                if (flags.rd_pos)
                begin
                    uw_next = uw_reg + rd_room;
                    uc_next = uc_reg + 1'b1;
                end
                else
                begin
                    fw_next = fw_reg + rd_room;
                    fc_next = fc_reg + 1'b1;
                end
                h_next = AW'(sum2);
            end
            default:
            begin
                h_next = h_reg;
            end
        endcase
    end

    always_comb
    begin
        done_next   = cmd.finish;
        status_next = status_reg;
        baddr_next  = baddr_reg;
        uwo_next    = uwo_reg;
        fwo_next    = fwo_reg;
        uco_next    = uco_reg;
        fco_next    = fco_reg;
        over_next   = over_reg;
        if (cmd.finish)
        begin
            status_next = cmd.status;
            baddr_next  = '0;
            uwo_next    = '0;
            fwo_next    = '0;
            uco_next    = '0;
            fco_next    = '0;
            over_next   = '0;
            if (cmd.status == ST_OK && kind_reg == KIND_ALLOC)
            begin
                baddr_next = ADDR_W'(h_ext + W'(1));
            end
            if (cmd.status == ST_OK && kind_reg == KIND_STATS)
            begin
                uwo_next  = CNT_W'(uw_reg);
                fwo_next  = CNT_W'(fw_reg);
                uco_next  = CNT_W'(uc_reg);
                fco_next  = CNT_W'(fc_reg);
                over_next = (total >= HEAP_N) ? '0 : OVER_W'(HEAP_N - total);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ready_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            ready_reg <= ready_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg     <= kind_next;
        words_reg    <= words_next;
        h_reg        <= h_next;
        end_reg      <= end_next;
        aux_reg      <= aux_next;
        hdr_reg      <= hdr_next;
        tend_reg     <= tend_next;
        room_reg     <= room_next;
        free_oob_reg <= free_oob_next;
        uw_reg       <= uw_next;
        fw_reg       <= fw_next;
        uc_reg       <= uc_next;
        fc_reg       <= fc_next;
        status_reg   <= status_next;
        baddr_reg    <= baddr_next;
        uwo_reg      <= uwo_next;
        fwo_reg      <= fwo_next;
        uco_reg      <= uco_next;
        fco_reg      <= fco_next;
        over_reg     <= over_next;
    end

    assign done           = done_reg;
    assign status         = status_reg;
    assign block_address  = baddr_reg;
    assign used_words     = uwo_reg;
    assign free_words     = fwo_reg;
    assign used_count     = uco_reg;
    assign free_count     = fco_reg;
    assign overhead_words = over_reg;

endmodule

FILE: hw/rtl/btheap_ctrl.sv
// Controller state machine of the heap: sequences init, allocate, free with
// merging, and the statistics walk. Uses btheap_pkg; drives btheap_dp.
module btheap_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    input  btheap_pkg::dp_flags_t  flags,
    output btheap_pkg::dp_cmd_t    cmd,
    output logic                   busy
);
    import btheap_pkg::*;

    ctl_state_t state_reg, state_next;
    logic       phase_reg, phase_next;
    ctl_state_t mg_return;

    assign mg_return = phase_reg ? S_IDLE : S_FR_RELOAD;

    always_comb
    begin
        state_next = state_reg;
        phase_next = phase_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                    state_next = S_DECODE;
            end
            S_DECODE:
            begin
                if (flags.kind == KIND_INIT)
                    state_next = S_INIT_LO;
                else if (!flags.ready)
                    state_next = S_IDLE;
                else
                begin
                    case (flags.kind)
                        KIND_ALLOC:
                            state_next = flags.words_zero ? S_IDLE : S_SCAN_RD;
                        KIND_FREE:
                            state_next = flags.free_oob ? S_IDLE : S_FR_RD_H;
                        default:
                            state_next = S_ST_RD;
                    endcase
                end
            end
            S_INIT_LO:   state_next = S_INIT_HI;
            S_INIT_HI:   state_next = S_IDLE;
            S_SCAN_RD:   state_next = S_SCAN;
            S_SCAN:
            begin
                if (flags.fit)
                    state_next = flags.split ? S_AL_SPLIT0 : S_AL_RD_END;
                else if (flags.next_oob)
                    state_next = S_IDLE;
            end
            S_AL_SPLIT0: state_next = S_AL_SPLIT1;
            S_AL_SPLIT1: state_next = S_AL_SPLIT2;
            S_AL_SPLIT2: state_next = S_AL_SPLIT3;
            S_AL_SPLIT3: state_next = S_IDLE;
            S_AL_RD_END: state_next = S_AL_END_CK;
            S_AL_END_CK:
                state_next = (flags.mismatch || flags.rd_pos) ? S_IDLE : S_AL_WR_H;
            S_AL_WR_H:   state_next = S_AL_WR_END;
            S_AL_WR_END: state_next = S_IDLE;
            S_FR_RD_H:   state_next = S_FR_H_CK;
            S_FR_H_CK:
                state_next = (flags.rd_neg || flags.end_oob) ? S_IDLE : S_FR_RD_END;
            S_FR_RD_END: state_next = S_FR_END_CK;
            S_FR_END_CK:
                state_next = (flags.rd_neg || flags.mismatch) ? S_IDLE : S_FR_WR_H;
            S_FR_WR_H:   state_next = S_FR_WR_END;
            S_FR_WR_END:
                state_next = flags.h_zero ? S_FR_RELOAD : S_FR_RD_HM1;
            S_FR_RD_HM1: state_next = S_FR_PREV_CK;
            S_FR_PREV_CK:
                state_next = flags.prev_skip ? S_FR_RELOAD : S_FR_RD_PREV;
            S_FR_RD_PREV: state_next = S_FR_PREV_TAG;
            S_FR_PREV_TAG:
            begin
                if (flags.rd_neg)
                begin
                    state_next = S_MG_RD;
                    phase_next = 1'b0;
                end
                else
                    state_next = S_FR_RELOAD;
            end
            S_MG_RD:
                state_next = flags.ls_oob ? mg_return : S_MG_CK;
            S_MG_CK:
                state_next = flags.le_oob ? mg_return : S_MG_W0;
            S_MG_W0:     state_next = S_MG_W1;
            S_MG_W1:     state_next = mg_return;
            S_FR_RELOAD: state_next = S_FR_NXT_CK;
            S_FR_NXT_CK:
                state_next = flags.next_oob ? S_IDLE : S_FR_NXT_TAG;
            S_FR_NXT_TAG:
            begin
                if (flags.rd_neg)
                begin
                    state_next = S_MG_RD;
                    phase_next = 1'b1;
                end
                else
                    state_next = S_IDLE;
            end
            S_ST_RD:     state_next = S_ST_WALK;
            S_ST_WALK:
            begin
                if (flags.next_oob)
                    state_next = S_ST_FIN;
            end
            S_ST_FIN:    state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op     = OP_IDLE;
        cmd.finish = 1'b0;
        cmd.status = ST_OK;
        busy       = (state_reg != S_IDLE);
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                    cmd.op = OP_LATCH;
            end
            S_DECODE:
            begin
                if (flags.kind != KIND_INIT)
                begin
                    if (!flags.ready)
                    begin
                        cmd.finish = 1'b1;
                        cmd.status = ST_NOINIT;
                    end
                    else if (flags.kind == KIND_ALLOC && flags.words_zero)
                    begin
                        cmd.finish = 1'b1;
                        cmd.status = ST_NOFIT;
                    end
                    else if (flags.kind == KIND_FREE && flags.free_oob)
                    begin
                        cmd.finish = 1'b1;
                        cmd.status = ST_RANGE;
                    end
                end
            end
            S_INIT_LO:
                cmd.op = OP_INIT_LO;
            S_INIT_HI:
            begin
                cmd.op     = OP_INIT_HI;
                cmd.finish = 1'b1;
            end
            S_SCAN_RD, S_FR_RD_H, S_FR_RELOAD, S_ST_RD:
                cmd.op = OP_RD_H;
            S_SCAN:
            begin
                cmd.op = OP_SCAN;
                if (!flags.fit && flags.next_oob)
                begin
                    cmd.finish = 1'b1;
                    cmd.status = ST_NOFIT;
                end
            end
            S_AL_SPLIT0:
                cmd.op = OP_SPLIT0;
            S_AL_SPLIT1:
                cmd.op = OP_SPLIT1;
            S_AL_SPLIT2:
                cmd.op = OP_SPLIT2;
            S_AL_SPLIT3:
            begin
                cmd.op     = OP_SPLIT3;
                cmd.finish = 1'b1;
            end
            S_AL_RD_END, S_FR_RD_END:
                cmd.op = OP_RD_END;
            S_AL_END_CK:
            begin
                cmd.op = OP_END_CK;
                if (flags.mismatch || flags.rd_pos)
                begin
                    cmd.finish = 1'b1;
                    cmd.status = ST_BAD;
                end
            end
            S_AL_WR_H, S_FR_WR_H:
                cmd.op = OP_WR_H_NEG;
            S_AL_WR_END:
            begin
                cmd.op     = OP_WR_END_NEG;
                cmd.finish = 1'b1;
            end
            S_FR_H_CK:
            begin
                cmd.op = OP_HDR_CK;
                if (flags.rd_neg || flags.end_oob)
                begin
                    cmd.finish = 1'b1;
                    cmd.status = ST_BAD;
                end
            end
            S_FR_END_CK:
            begin
                cmd.op = OP_END_CK;
                if (flags.rd_neg || flags.mismatch)
                begin
                    cmd.finish = 1'b1;
                    cmd.status = ST_BAD;
                end
            end
            S_FR_WR_END:
                cmd.op = OP_WR_END_NEG;
            S_FR_RD_HM1:
                cmd.op = OP_RD_HM1;
            S_FR_PREV_CK:
                cmd.op = OP_PREV_CK;
            S_FR_RD_PREV:
                cmd.op = OP_RD_AUX;
            S_FR_PREV_TAG:
            begin
                if (flags.rd_neg)
                    cmd.op = OP_PREV_TAKE;
            end
            S_MG_RD:
            begin
                cmd.op     = OP_MG_RD;
                cmd.finish = flags.ls_oob && phase_reg;
            end
            S_MG_CK:
            begin
                cmd.op     = OP_MG_CK;
                cmd.finish = flags.le_oob && phase_reg;
            end
            S_MG_W0:
                cmd.op = OP_MG_W0;
            S_MG_W1:
            begin
                cmd.op     = OP_MG_W1;
                cmd.finish = phase_reg;
            end
            S_FR_NXT_CK:
            begin
                cmd.op     = OP_NXT_CK;
                cmd.finish = flags.next_oob;
            end
            S_FR_NXT_TAG:
                cmd.finish = !flags.rd_neg;
            S_ST_WALK:
                cmd.op = OP_ST_STEP;
            S_ST_FIN:
                cmd.finish = 1'b1;
            default:
                cmd.op = OP_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            phase_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

endmodule

FILE: hw/rtl/boundary_tag_first_fit_heap.sv
// Channel    Qualifier          Word
// command    start && !busy     kind, size_bytes, address
// result     done (1 cycle)     status, block_address, used_words, free_words,
//                               used_count, free_count, overhead_words
//
// Init writes the two tags of one free block over the whole heap. Allocate
// reads block headers until one fits, then writes the tags; statistics reads
// every block header. Free checks both tags of the block and merges neighbours.
// The walk rate is set by the single tag RAM read port, one header a cycle.
// Reset clears the controller and the heap-ready flag; the tag RAM is not
// cleared. The result is held for exactly one cycle and cannot be stalled.
module boundary_tag_first_fit_heap #(
    parameter int HEAP_WORDS = 1024
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [btheap_pkg::KIND_W-1:0]    kind,
    input  logic [btheap_pkg::SIZE_W-1:0]    size_bytes,
    input  logic [btheap_pkg::ADDR_W-1:0]    address,
    output logic                             busy,
    output logic                             done,
    output logic [btheap_pkg::STATUS_W-1:0]  status,
    output logic [btheap_pkg::ADDR_W-1:0]    block_address,
    output logic [btheap_pkg::CNT_W-1:0]     used_words,
    output logic [btheap_pkg::CNT_W-1:0]     free_words,
    output logic [btheap_pkg::CNT_W-1:0]     used_count,
    output logic [btheap_pkg::CNT_W-1:0]     free_count,
    output logic [btheap_pkg::OVER_W-1:0]    overhead_words
);
    import btheap_pkg::*;

    dp_cmd_t   cmd;
    dp_flags_t flags;

    btheap_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .flags (flags),
        .cmd   (cmd),
        .busy  (busy)
    );

    btheap_dp #(
        .HEAP_WORDS (HEAP_WORDS)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .kind           (kind),
        .size_bytes     (size_bytes),
        .address        (address),
        .flags          (flags),
        .done           (done),
        .status         (status),
        .block_address  (block_address),
        .used_words     (used_words),
        .free_words     (free_words),
        .used_count     (used_count),
        .free_count     (free_count),
        .overhead_words (overhead_words)
    );

endmodule

FILE: hw/rtl/btheap_chk.sv
// Port-level checker for the heap, bound to the top level below.
// Uses btheap_pkg for the status codes.
module btheap_chk (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             start,
    input logic                             busy,
    input logic                             done,
    input logic [btheap_pkg::STATUS_W-1:0]  status,
    input logic [btheap_pkg::ADDR_W-1:0]    block_address,
    input logic [btheap_pkg::CNT_W-1:0]     used_words,
    input logic [btheap_pkg::CNT_W-1:0]     free_words,
    input logic [btheap_pkg::CNT_W-1:0]     used_count,
    input logic [btheap_pkg::CNT_W-1:0]     free_count,
    input logic [btheap_pkg::OVER_W-1:0]    overhead_words
);
    import btheap_pkg::*;

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("accepted word did not raise busy");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result word without a command in progress");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        done && status != ST_OK |-> block_address == '0 && used_words == '0 &&
            free_words == '0 && used_count == '0 && free_count == '0 &&
            overhead_words == '0)
        else $error("failed command returned nonzero fields");

endmodule

bind boundary_tag_first_fit_heap btheap_chk u_btheap_chk (.*);

FILE: dv/boundary_tag_first_fit_heap_tb.sv
// Self-checking testbench for boundary_tag_first_fit_heap: directed table then random words.
// Uses btheap_pkg from hw/rtl for field widths, operation kinds and status codes.
// Predicts each result with its own tag-store model or a typed table row, and compares the whole word.
module boundary_tag_first_fit_heap_tb;

    import btheap_pkg::*;

    localparam int HEAP_WORDS = 1024;
    localparam int PERIOD     = 8;
    localparam int RAND_ITEMS = 600;
    localparam int LIMIT      = 1000000;
    localparam int PLAN_N     = 25;

    typedef struct packed {
        kind_t               kind;
        logic [SIZE_W-1:0]   size;
        logic [ADDR_W-1:0]   addr;
    } heap_cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   blk;
        logic [CNT_W-1:0]    used_w;
        logic [CNT_W-1:0]    free_w;
        logic [CNT_W-1:0]    used_c;
        logic [CNT_W-1:0]    free_c;
        logic [OVER_W-1:0]   over;
    } heap_reply_t;

    typedef struct {
        kind_t       kind;
        int          size;
        int          addr;
        bit          typed;
        heap_reply_t want;
    } plan_row_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic [KIND_W-1:0]   kind;
    logic [SIZE_W-1:0]   size_bytes;
    logic [ADDR_W-1:0]   address;
    logic                busy;
    logic                done;
    logic [STATUS_W-1:0] status;
    logic [ADDR_W-1:0]   block_address;
    logic [CNT_W-1:0]    used_words;
    logic [CNT_W-1:0]    free_words;
    logic [CNT_W-1:0]    used_count;
    logic [CNT_W-1:0]    free_count;
    logic [OVER_W-1:0]   overhead_words;

    int          tag_mem [HEAP_WORDS];
    bit          tag_seen [HEAP_WORDS];
    bit          heap_up;
    bit          stray_read;

    heap_reply_t reply_q [$];
    int          live_addr [$];
    heap_reply_t got;
    heap_reply_t want_now;
    int          failures;
    int          results_seen;
    int          cycle_cnt;
    int          calm_left;
    int          n_items;
    int          n_init;
    int          n_alloc;
    int          n_free;
    int          n_stats;
    int          n_refused;

    plan_row_t plan [PLAN_N] = '{
        '{KIND_ALLOC, 4,    0,    1'b1, '{ST_NOINIT, 0, 0, 0, 0, 0, 0}},
        '{KIND_FREE,  0,    1,    1'b1, '{ST_NOINIT, 0, 0, 0, 0, 0, 0}},
        '{KIND_STATS, 0,    0,    1'b1, '{ST_NOINIT, 0, 0, 0, 0, 0, 0}},
        '{KIND_INIT,  0,    0,    1'b1, '{ST_OK, 0, 0, 0, 0, 0, 0}},
        '{KIND_STATS, 0,    0,    1'b1, '{ST_OK, 0, 0, 1022, 0, 1, 2}},
        '{KIND_ALLOC, 0,    0,    1'b1, '{ST_NOFIT, 0, 0, 0, 0, 0, 0}},
        '{KIND_ALLOC, 4096, 0,    1'b1, '{ST_NOFIT, 0, 0, 0, 0, 0, 0}},
        '{KIND_FREE,  0,    0,    1'b1, '{ST_RANGE, 0, 0, 0, 0, 0, 0}},
        '{KIND_ALLOC, 1,    0,    1'b1, '{ST_OK, 1, 0, 0, 0, 0, 0}},
        '{KIND_FREE,  0,    1,    1'b0, '0},
        '{KIND_FREE,  0,    1,    1'b1, '{ST_BAD, 0, 0, 0, 0, 0, 0}},
        '{KIND_ALLOC, 4088, 0,    1'b1, '{ST_OK, 1, 0, 0, 0, 0, 0}},
        '{KIND_STATS, 0,    0,    1'b0, '0},
        '{KIND_ALLOC, 4,    0,    1'b1, '{ST_NOFIT, 0, 0, 0, 0, 0, 0}},
        '{KIND_FREE,  0,    1,    1'b0, '0},
        '{KIND_INIT,  0,    0,    1'b1, '{ST_OK, 0, 0, 0, 0, 0, 0}},
        '{KIND_ALLOC, 4080, 0,    1'b0, '0},
        '{KIND_FREE,  0,    1,    1'b0, '0},
        '{KIND_ALLOC, 4068, 0,    1'b0, '0},
        '{KIND_ALLOC, 12,   0,    1'b0, '0},
        '{KIND_STATS, 0,    0,    1'b0, '0},
        '{KIND_FREE,  0,    1,    1'b0, '0},
        '{KIND_FREE,  0,    1020, 1'b0, '0},
        '{KIND_STATS, 0,    0,    1'b0, '0},
        '{KIND_FREE,  0,    1,    1'b1, '{ST_BAD, 0, 0, 0, 0, 0, 0}}
    };

    boundary_tag_first_fit_heap #(
        .HEAP_WORDS(HEAP_WORDS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .kind          (kind),
        .size_bytes    (size_bytes),
        .address       (address),
        .busy          (busy),
        .done          (done),
        .status        (status),
        .block_address (block_address),
        .used_words    (used_words),
        .free_words    (free_words),
        .used_count    (used_count),
        .free_count    (free_count),
        .overhead_words(overhead_words)
    );

    initial clk = 1'b0;
    always #(PERIOD / 2) clk = ~clk;

    function automatic bit in_heap(input int i);
        return (i >= 0) && (i < HEAP_WORDS);
    endfunction

    function automatic int tag_rd(input int i);
        if (!tag_seen[i])
            stray_read = 1'b1;
        return tag_mem[i];
    endfunction

    function automatic void tag_wr(input int i, input int v);
        tag_mem[i]  = v;
        tag_seen[i] = 1'b1;
    endfunction

    function automatic int room_of(input int i);
        int t;
        t = tag_rd(i);
        return (t < 0) ? -t : t;
    endfunction

    function automatic void merge_up(input int h);
        int lo_start;
        int lo_end;
        int r;
        lo_start = h + room_of(h) + 2;
        if (!in_heap(lo_start))
            return;
        lo_end = lo_start + room_of(lo_start) + 1;
        if (!in_heap(lo_end))
            return;
        r = lo_end - h - 1;
        tag_wr(h, -r);
        tag_wr(lo_end, -r);
    endfunction

    function automatic logic [STATUS_W-1:0] take_first_fit(input int bytes, output int at);
        int words;
        int h;
        int r;
        int fin;
        int rest;
        words = (bytes + 3) / 4;
        at    = 0;
        if (words <= 0)
            return ST_NOFIT;
        h = 0;
        while (in_heap(h))
        begin
            r   = room_of(h);
            fin = h + r + 1;
            if (tag_rd(h) < 0 && words <= r && in_heap(fin))
            begin
                rest = r - words - 2;
                if (rest > 0)
                begin
                    tag_wr(h, words);
                    tag_wr(h + words + 1, words);
                    tag_wr(h + words + 2, -rest);
                    tag_wr(fin, -rest);
                end
                else
                begin
                    if (tag_rd(h) != tag_rd(fin) || tag_rd(fin) > 0)
                        return ST_BAD;
                    tag_wr(h, -tag_rd(h));
                    tag_wr(fin, -tag_rd(fin));
                end
                at = h + 1;
                return ST_OK;
            end
            h = fin + 1;
        end
        return ST_NOFIT;
    endfunction

    function automatic logic [STATUS_W-1:0] free_block(input int user_addr);
        int h;
        int fin;
        int prv;
        int nxt;
        h = user_addr - 1;
        if (!in_heap(h))
            return ST_RANGE;
        if (tag_rd(h) < 0)
            return ST_BAD;
        fin = h + room_of(h) + 1;
        if (!in_heap(fin) || tag_rd(fin) < 0)
            return ST_BAD;
        if (tag_rd(h) != tag_rd(fin))
            return ST_BAD;
        tag_wr(h, -tag_rd(h));
        tag_wr(fin, -tag_rd(fin));
        if (h > 0)
        begin
            prv = h - room_of(h - 1) - 2;
            if (in_heap(prv) && tag_rd(prv) < 0)
            begin
                merge_up(prv);
                h = prv;
            end
        end
        nxt = h + room_of(h) + 2;
        if (in_heap(nxt) && tag_rd(nxt) < 0)
            merge_up(h);
        return ST_OK;
    endfunction

    // Returns 0 and leaves the state untouched when the word would read a tag never written.
    function automatic bit heap_step(input heap_cmd_t c, output heap_reply_t rep);
        int          saved_mem [HEAP_WORDS];
        bit          saved_seen [HEAP_WORDS];
        bit          saved_up;
        int          at;
        int          h;
        int          r;
        int unsigned uw;
        int unsigned fw;
        int unsigned uc;
        int unsigned fc;
        int unsigned tot;
        for (int i = 0; i < HEAP_WORDS; i++)
        begin
            saved_mem[i]  = tag_mem[i];
            saved_seen[i] = tag_seen[i];
        end
        saved_up   = heap_up;
        stray_read = 1'b0;
        rep        = '0;
        if (c.kind == KIND_INIT)
        begin
            tag_wr(0, -(HEAP_WORDS - 2));
            tag_wr(HEAP_WORDS - 1, -(HEAP_WORDS - 2));
            heap_up = 1'b1;
        end
        else if (!heap_up)
            rep.status = ST_NOINIT;
        else if (c.kind == KIND_ALLOC)
        begin
            rep.status = take_first_fit(int'(c.size), at);
            if (rep.status == ST_OK)
                rep.blk = at[ADDR_W-1:0];
        end
        else if (c.kind == KIND_FREE)
            rep.status = free_block(int'(c.addr));
        else
        begin
            uw = 0;
            fw = 0;
            uc = 0;
            fc = 0;
            h  = 0;
            while (in_heap(h))
            begin
                r = room_of(h);
                if (tag_rd(h) > 0)
                begin
                    uw += r;
                    uc++;
                end
                else
                begin
                    fw += r;
                    fc++;
                end
                h = h + r + 2;
            end
            tot        = uw + fw;
            rep.used_w = uw[CNT_W-1:0];
            rep.free_w = fw[CNT_W-1:0];
            rep.used_c = uc[CNT_W-1:0];
            rep.free_c = fc[CNT_W-1:0];
            if (tot < HEAP_WORDS)
            begin
                tot      = HEAP_WORDS - tot;
                rep.over = tot[OVER_W-1:0];
            end
        end
        if (stray_read)
        begin
            for (int i = 0; i < HEAP_WORDS; i++)
            begin
                tag_mem[i]  = saved_mem[i];
                tag_seen[i] = saved_seen[i];
            end
            heap_up = saved_up;
            return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic int pick_gap();
        int p;
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        p = $urandom_range(0, 99);
        if (p < 3)
        begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        if (p < 55)
            return 0;
        if (p < 90)
            return $urandom_range(1, 4);
        return $urandom_range(8, 60);
    endfunction

    task automatic send_word(input heap_cmd_t c);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start      <= 1'b1;
        kind       <= c.kind;
        size_bytes <= c.size;
        address    <= c.addr;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic issue(input heap_cmd_t c, input heap_reply_t want);
        n_items++;
        if (want.status != ST_OK)
            n_refused++;
        else if (c.kind == KIND_ALLOC)
        begin
            n_alloc++;
            live_addr.push_back(int'(want.blk));
        end
        else if (c.kind == KIND_FREE)
            n_free++;
        else if (c.kind == KIND_STATS)
            n_stats++;
        if (c.kind == KIND_INIT)
        begin
            n_init++;
            live_addr.delete();
        end
        reply_q.push_back(want);
        send_word(c);
    endtask

    task automatic report(input string what, input heap_reply_t want, input heap_reply_t seen);
        if (failures < 10)
        begin
            $write("%s: exp st=%0d blk=%0d uw=%0d fw=%0d uc=%0d fc=%0d ov=%0d, ",
                   what, want.status, want.blk, want.used_w, want.free_w, want.used_c,
                   want.free_c, want.over);
            $display("got st=%0d blk=%0d uw=%0d fw=%0d uc=%0d fc=%0d ov=%0d",
                     seen.status, seen.blk, seen.used_w, seen.free_w, seen.used_c,
                     seen.free_c, seen.over);
        end
        failures++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            got = {status, block_address, used_words, free_words, used_count, free_count,
                   overhead_words};
            results_seen++;
            if (reply_q.size() == 0)
                report("result word with nothing expected", '0, got);
            else
            begin
                want_now = reply_q.pop_front();
                if (got !== want_now)
                    report("result word mismatch", want_now, got);
            end
        end
    end

    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles, %0d results outstanding", cycle_cnt, reply_q.size());
        $display("boundary_tag_first_fit_heap_tb failed");
        $finish;
    end

    initial
    begin
        heap_cmd_t   cmd;
        heap_reply_t want;
        bit          ok;
        int          pick;
        int          p;
        int          q;
        int          free_cut;
        rst_n        = 1'b0;
        start        = 1'b0;
        kind         = '0;
        size_bytes   = '0;
        address      = '0;
        heap_up      = 1'b0;
        failures     = 0;
        results_seen = 0;
        calm_left    = 0;
        n_items      = 0;
        n_init       = 0;
        n_alloc      = 0;
        n_free       = 0;
        n_stats      = 0;
        n_refused    = 0;
        for (int i = 0; i < HEAP_WORDS; i++)
        begin
            tag_mem[i]  = 0;
            tag_seen[i] = 1'b0;
        end
        repeat (7) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        for (int i = 0; i < PLAN_N; i++)
        begin
            cmd      = '0;
            cmd.kind = plan[i].kind;
            cmd.size = SIZE_W'(plan[i].size);
            cmd.addr = ADDR_W'(plan[i].addr);
            if (!heap_step(cmd, want))
                continue;
            if (plan[i].typed)
                want = plan[i].want;
            issue(cmd, want);
        end

        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            ok   = 1'b0;
            pick = -1;
            for (int tries = 0; tries < 16 && !ok; tries++)
            begin
                pick     = -1;
                cmd      = '0;
                p        = $urandom_range(0, 99);
                free_cut = (live_addr.size() == 0) ? 22 : ((live_addr.size() > 48) ? 70 : 50);
                if (p < 2)
                    cmd.kind = KIND_INIT;
                else if (p < 14)
                    cmd.kind = KIND_STATS;
                else if (p < 22)
                begin
                    cmd.kind = KIND_FREE;
                    cmd.addr = ADDR_W'($urandom_range(0, HEAP_WORDS - 1));
                end
                else if (p < free_cut)
                begin
                    cmd.kind = KIND_FREE;
                    pick     = $urandom_range(0, live_addr.size() - 1);
                    cmd.addr = ADDR_W'(live_addr[pick]);
                end
                else
                begin
                    cmd.kind = KIND_ALLOC;
                    q        = $urandom_range(0, 99);
                    if (q < 3)
                        cmd.size = SIZE_W'((q == 0) ? 0 : 4096);
                    else if (q < 72)
                        cmd.size = SIZE_W'($urandom_range(1, 32));
                    else if (q < 92)
                        cmd.size = SIZE_W'($urandom_range(33, 512));
                    else
                        cmd.size = SIZE_W'($urandom_range(513, 4096));
                end
                if (cmd.kind == KIND_FREE && cmd.addr != 0 && !tag_seen[cmd.addr - 1])
                    continue;
                ok = heap_step(cmd, want);
                if (!ok && pick >= 0)
                    live_addr.delete(pick);
            end
            if (!ok)
            begin
                pick     = -1;
                cmd      = '0;
                cmd.kind = KIND_INIT;
                ok       = heap_step(cmd, want);
            end
            if (pick >= 0)
                live_addr.delete(pick);
            issue(cmd, want);
        end
        start <= 1'b0;

        while (reply_q.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);

        $display("sent %0d words: %0d inits, %0d allocations and %0d frees granted, %0d reports",
                 n_items, n_init, n_alloc, n_free, n_stats);
        $display("%0d words refused with an error status, %0d results checked, %0d failures",
                 n_refused, results_seen, failures);
        if (failures == 0 && reply_q.size() == 0)
            $display("boundary_tag_first_fit_heap_tb passed");
        else
            $display("boundary_tag_first_fit_heap_tb failed");
        $finish;
    end

endmodule
